[src/bilinear_table_interpolator_assert.svh]
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define BTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bti_pkg;

  localparam int SPEED_POINTS_MAX_DEF = 16;
  localparam int PITCH_POINTS_MAX_DEF = 16;

  localparam int CNT_W  = 5;
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic [1:0] OP_WR_SPEED = 2'd0;
  localparam logic [1:0] OP_WR_PITCH = 2'd1;
  localparam logic [1:0] OP_WR_CELL  = 2'd2;
  localparam logic [1:0] OP_LOOKUP   = 2'd3;

  localparam logic CFG_SPEED_CNT = 1'b0;
  localparam logic CFG_PITCH_CNT = 1'b1;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [3:0]          row_index;
    logic [3:0]          col_index;
    logic [15:0]         speed_value;
    logic signed [15:0]  pitch_value;
    logic signed [31:0]  cell_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic               is_lookup_result;
    logic               axis_empty;
  } out_t;

  typedef struct packed {
    logic             reg_index;
    logic [CNT_W-1:0] wr_data;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [17:0] num;
    logic signed [17:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] frac;
  } div_rsp_t;

endpackage
`default_nettype wire

[src/bti_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface bti_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/bti_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rd_data_r
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/bti_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bti_pkg::div_req_t req,
  output bti_pkg::div_rsp_t      rsp
);
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;
  logic [18:0]                   rem_r, rem_nxt;
  logic [17:0]                   den_r, den_nxt;
  logic [bti_pkg::FRAC_W-1:0]    quo_r, quo_nxt;
  logic [17:0]                   num_mag, den_mag;
  logic [18:0]                   rem_sh;

  // magnitudes; a negative quotient clamps to zero anyway
  assign num_mag = req.num[17] ? 18'(-req.num) : 18'(req.num);
  assign den_mag = req.den[17] ? 18'(-req.den) : 18'(req.den);
  assign rem_sh  = {rem_r[17:0], 1'b0};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      if (req.den == '0 || req.num == '0 || (req.num[17] != req.den[17])) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else if (num_mag >= den_mag) begin
        quo_nxt  = bti_pkg::FRAC_ONE;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = 5'd16;
        rem_nxt  = {1'b0, num_mag};
        den_nxt  = den_mag;
        quo_nxt  = '0;
      end
    end else if (busy_r) begin
      // one restoring step per cycle
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[bti_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[bti_pkg::FRAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.frac = quo_r;
endmodule
`default_nettype wire

[src/bti_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_blend (
  input  wire logic                       clk,
  input  wire logic signed [31:0]         lo,
  input  wire logic signed [31:0]         hi,
  input  wire logic [bti_pkg::FRAC_W-1:0] frac,
  output logic signed [31:0]              blend
);
  logic signed [31:0] lo_r;
  logic signed [50:0] prod_r;
  logic signed [32:0] diff;
  logic signed [50:0] prod_nxt;
  logic signed [50:0] prod_adj;
  logic signed [50:0] prod_sh;

  assign diff     = 33'(hi) - 33'(lo);
  assign prod_nxt = diff * $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    lo_r   <= lo;
    prod_r <= prod_nxt;
  end

  // divide by 2^16 rounding toward zero
  assign prod_adj = prod_r + (prod_r[50] ? 51'sd65535 : 51'sd0);
  assign prod_sh  = prod_adj >>> 16;
  assign blend    = lo_r + $signed(prod_sh[31:0]);
endmodule
`default_nettype wire

[src/bilinear_table_interpolator.sv]
// write requests: taken while idle, result passed through the finish step to the output register
// lookup: per axis a first-point read, a last-point read and a lower-bound scan of points
// up to the bracketing index, then the divider; then 4 cell reads and, unless both spans
// are zero, the blend steps MUL0 to MUL4; one request in flight, taken only while idle
// reset (synchronous, rst_n low) clears counts and runs a clearing pass over the cell
// table of SPEED_POINTS_MAX * PITCH_POINTS_MAX entries before the first request is taken
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_table_interpolator_assert.svh"
module bilinear_table_interpolator #(
  parameter int SPEED_POINTS_MAX = bti_pkg::SPEED_POINTS_MAX_DEF,
  parameter int PITCH_POINTS_MAX = bti_pkg::PITCH_POINTS_MAX_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bti_chan_if.sink   in_ch,
  bti_chan_if.source out_ch,
  bti_chan_if.sink   cfg_ch
);
  localparam int SAW    = $clog2(SPEED_POINTS_MAX);
  localparam int PAW    = $clog2(PITCH_POINTS_MAX);
  localparam int MAXP   = (SPEED_POINTS_MAX > PITCH_POINTS_MAX) ?
                          SPEED_POINTS_MAX : PITCH_POINTS_MAX;
  localparam int IXW    = $clog2(MAXP);
  localparam int NW     = $clog2(MAXP + 1);
  localparam int CDEPTH = SPEED_POINTS_MAX * PITCH_POINTS_MAX;
  localparam int CAW    = $clog2(CDEPTH);

  // sequencer states
  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_AX_FIRST = 4'd2;
  localparam logic [3:0] ST_AX_LAST  = 4'd3;
  localparam logic [3:0] ST_AX_SRCH  = 4'd4;
  localparam logic [3:0] ST_DIV      = 4'd5;
  localparam logic [3:0] ST_CELL     = 4'd6;
  localparam logic [3:0] ST_MUL0     = 4'd7;
  localparam logic [3:0] ST_MUL1     = 4'd8;
  localparam logic [3:0] ST_MUL2     = 4'd9;
  localparam logic [3:0] ST_MUL3     = 4'd10;
  localparam logic [3:0] ST_MUL4     = 4'd11;
  localparam logic [3:0] ST_FIN      = 4'd12;

  logic [3:0]                 state_r, state_nxt;
  logic [CAW-1:0]             clr_r, clr_nxt;
  logic [bti_pkg::CNT_W-1:0]  spd_cnt_r, spd_cnt_nxt;
  logic [bti_pkg::CNT_W-1:0]  pit_cnt_r, pit_cnt_nxt;
  logic                       axis_r, axis_nxt;        // 0 speed, 1 pitch
  logic [IXW-1:0]             idx_r, idx_nxt;
  logic signed [16:0]         q_r, q_nxt;              // clamped query
  logic signed [16:0]         prev_r, prev_nxt;        // point before idx
  logic signed [15:0]         pitq_r, pitq_nxt;
  logic [IXW-1:0]             r_lo_r, r_lo_nxt, r_hi_r, r_hi_nxt;
  logic [IXW-1:0]             c_lo_r, c_lo_nxt, c_hi_r, c_hi_nxt;
  logic                       zs_r, zs_nxt, zp_r, zp_nxt;  // zero span per axis
  logic [bti_pkg::FRAC_W-1:0] t_r, t_nxt, u_r, u_nxt;
  logic [1:0]                 ccnt_r, ccnt_nxt;
  logic signed [31:0]         cq_r [4];                // q11 q21 q12 q22
  logic signed [31:0]         a_r, a_nxt, b_r, b_nxt;
  logic signed [31:0]         res_r, res_nxt;
  logic                       lookup_r, lookup_nxt;
  logic                       empty_r, empty_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bti_pkg::out_t              out_data_r, out_data_nxt;

  logic [NW-1:0]        n_spd, n_pit, n_cur;
  logic [IXW-1:0]       last_ix;
  logic [IXW-1:0]       ax_raddr;
  logic [15:0]          spd_rd, pit_rd;
  logic signed [16:0]   ax_rd;
  logic signed [16:0]   alo;
  logic                 spd_we, pit_we;
  logic                 cell_we;
  logic [CAW-1:0]       cell_waddr, cell_raddr;
  logic [31:0]          cell_wdata, cell_rd;
  bti_pkg::div_req_t    div_req;
  bti_pkg::div_rsp_t    div_rsp;
  logic signed [31:0]   bl_lo, bl_hi, bl_out;
  logic [bti_pkg::FRAC_W-1:0] bl_frac;
  logic                 in_acc;
  bti_pkg::in_t         req;

  function automatic logic [CAW-1:0] cell_addr(input logic [IXW-1:0] r,
                                               input logic [IXW-1:0] c);
    return CAW'(32'(r) * PITCH_POINTS_MAX + 32'(c));
  endfunction

  assign req    = in_ch.data;
  assign in_acc = in_ch.valid && in_ch.ready;

  // counts above the table size saturate
  assign n_spd   = NW'((32'(spd_cnt_r) > SPEED_POINTS_MAX) ? SPEED_POINTS_MAX
                                                            : 32'(spd_cnt_r));
  assign n_pit   = NW'((32'(pit_cnt_r) > PITCH_POINTS_MAX) ? PITCH_POINTS_MAX
                                                            : 32'(pit_cnt_r));
  assign n_cur   = axis_r ? n_pit : n_spd;
  assign last_ix = IXW'(n_cur - NW'(1));

  // shared axis read path, both axes widened to 17-bit signed
  assign ax_rd = axis_r ? {pit_rd[15], pit_rd} : {1'b0, spd_rd};
  assign alo   = (idx_r == '0) ? ax_rd : prev_r;

  // axis point and cell storage
  bti_ram #(.W(16), .D(SPEED_POINTS_MAX)) u_spd_ram (
    .clk, .we(spd_we), .waddr(SAW'(req.row_index)), .wdata(req.speed_value),
    .raddr(SAW'(ax_raddr)), .rd_data_r(spd_rd)
  );

  bti_ram #(.W(16), .D(PITCH_POINTS_MAX)) u_pit_ram (
    .clk, .we(pit_we), .waddr(PAW'(req.col_index)), .wdata(req.pitch_value),
    .raddr(PAW'(ax_raddr)), .rd_data_r(pit_rd)
  );

  bti_ram #(.W(32), .D(CDEPTH)) u_cell_ram (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rd_data_r(cell_rd)
  );

  // shared fraction divider and blend multiplier
  bti_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  bti_blend u_blend (.clk, .lo(bl_lo), .hi(bl_hi), .frac(bl_frac), .blend(bl_out));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    axis_nxt      = axis_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    prev_nxt      = prev_r;
    pitq_nxt      = pitq_r;
    r_lo_nxt      = r_lo_r;
    r_hi_nxt      = r_hi_r;
    c_lo_nxt      = c_lo_r;
    c_hi_nxt      = c_hi_r;
    zs_nxt        = zs_r;
    zp_nxt        = zp_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    ccnt_nxt      = ccnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    lookup_nxt    = lookup_r;
    empty_nxt     = empty_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ax_raddr      = '0;
    spd_we        = 1'b0;
    pit_we        = 1'b0;
    cell_we       = 1'b0;
    cell_waddr    = cell_addr(IXW'(req.row_index), IXW'(req.col_index));
    cell_wdata    = req.cell_value;
    cell_raddr    = '0;
    div_req.start = 1'b0;
    div_req.num   = 18'(q_r) - 18'(alo);
    div_req.den   = 18'(ax_rd) - 18'(alo);
    bl_lo         = cq_r[0];
    bl_hi         = cq_r[1];
    bl_frac       = t_r;

    unique case (state_r)
      ST_CLR: begin
        // zero the cell table one entry per cycle
        cell_we    = 1'b1;
        cell_waddr = clr_r;
        cell_wdata = '0;
        clr_nxt    = clr_r + CAW'(1);
        if (clr_r == CAW'(CDEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt    = '0;
          lookup_nxt = 1'b0;
          empty_nxt  = 1'b0;
          state_nxt  = ST_FIN;
          unique case (req.opcode)
            bti_pkg::OP_WR_SPEED: begin
              spd_we = 32'(req.row_index) < SPEED_POINTS_MAX;
            end
            bti_pkg::OP_WR_PITCH: begin
              pit_we = 32'(req.col_index) < PITCH_POINTS_MAX;
            end
            bti_pkg::OP_WR_CELL: begin
              cell_we = (32'(req.row_index) < SPEED_POINTS_MAX) &&
                        (32'(req.col_index) < PITCH_POINTS_MAX);
            end
            bti_pkg::OP_LOOKUP: begin
              lookup_nxt = 1'b1;
              if (n_spd == '0 || n_pit == '0) begin
                empty_nxt = 1'b1;
              end else begin
                axis_nxt  = 1'b0;
                q_nxt     = {1'b0, req.speed_value};
                pitq_nxt  = req.pitch_value;
                state_nxt = ST_AX_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_AX_FIRST: begin
        // raise query to the first point
        if (ax_rd > q_r) begin
          q_nxt = ax_rd;
        end
        ax_raddr  = last_ix;
        state_nxt = ST_AX_LAST;
      end
      ST_AX_LAST: begin
        // lower query to the last point
        if (ax_rd < q_r) begin
          q_nxt = ax_rd;
        end
        idx_nxt   = '0;
        state_nxt = ST_AX_SRCH;
      end
      ST_AX_SRCH: begin
        // lower-bound scan, one point per cycle
        if (ax_rd >= q_r || idx_r == last_ix) begin
          div_req.start = 1'b1;
          if (axis_r) begin
            c_hi_nxt = idx_r;
            c_lo_nxt = (idx_r == '0) ? idx_r : idx_r - IXW'(1);
            zp_nxt   = ax_rd == alo;
          end else begin
            r_hi_nxt = idx_r;
            r_lo_nxt = (idx_r == '0) ? idx_r : idx_r - IXW'(1);
            zs_nxt   = ax_rd == alo;
          end
          state_nxt = ST_DIV;
        end else begin
          prev_nxt = ax_rd;
          idx_nxt  = idx_r + IXW'(1);
          ax_raddr = idx_r + IXW'(1);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (!axis_r) begin
            t_nxt     = div_rsp.frac;
            axis_nxt  = 1'b1;
            q_nxt     = {pitq_r[15], pitq_r};
            state_nxt = ST_AX_FIRST;
          end else begin
            u_nxt      = div_rsp.frac;
            ccnt_nxt   = '0;
            cell_raddr = cell_addr(r_lo_r, c_lo_r);
            state_nxt  = ST_CELL;
          end
        end
      end
      ST_CELL: begin
        // fetch q11, q21, q12, q22 in turn
        ccnt_nxt = ccnt_r + 2'd1;
        unique case (ccnt_r)
          2'd0: cell_raddr = cell_addr(r_hi_r, c_lo_r);
          2'd1: cell_raddr = cell_addr(r_lo_r, c_hi_r);
          2'd2: cell_raddr = cell_addr(r_hi_r, c_hi_r);
          default: cell_raddr = '0;
        endcase
        if (ccnt_r == 2'd3) begin
          if (zs_r && zp_r) begin
            res_nxt   = cq_r[0];
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        a_nxt     = bl_out;
        bl_lo     = cq_r[2];
        bl_hi     = cq_r[3];
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        b_nxt     = bl_out;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        bl_lo     = a_r;
        bl_hi     = b_r;
        bl_frac   = u_r;
        state_nxt = ST_MUL4;
      end
      ST_MUL4: begin
        res_nxt   = bl_out;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hand result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.coefficient      = res_r;
          out_data_nxt.is_lookup_result = lookup_r;
          out_data_nxt.axis_empty       = empty_r;
          state_nxt                     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    spd_cnt_nxt = spd_cnt_r;
    pit_cnt_nxt = pit_cnt_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        bti_pkg::CFG_SPEED_CNT: spd_cnt_nxt = cfg_ch.data.wr_data;
        bti_pkg::CFG_PITCH_CNT: pit_cnt_nxt = cfg_ch.data.wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      spd_cnt_r   <= '0;
      pit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      spd_cnt_r   <= spd_cnt_nxt;
      pit_cnt_r   <= pit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    axis_r     <= axis_nxt;
    idx_r      <= idx_nxt;
    q_r        <= q_nxt;
    prev_r     <= prev_nxt;
    pitq_r     <= pitq_nxt;
    r_lo_r     <= r_lo_nxt;
    r_hi_r     <= r_hi_nxt;
    c_lo_r     <= c_lo_nxt;
    c_hi_r     <= c_hi_nxt;
    zs_r       <= zs_nxt;
    zp_r       <= zp_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    ccnt_r     <= ccnt_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    lookup_r   <= lookup_nxt;
    empty_r    <= empty_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == ST_CELL) begin
      cq_r[ccnt_r] <= $signed(cell_rd);
    end
  end

  assign in_ch.ready  = state_r == ST_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // the block is busy in the cycle after it takes a request
  `BTI_ASSERT_NEXT(a_busy_after_req, in_acc, !in_ch.ready, "ready high right after a request")
  // results only come from the finish step
  `BTI_ASSERT_NOW(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN,
                  "result loaded outside finish step")
  // divider fraction stays within one
  `BTI_ASSERT_NOW(a_frac_range, div_rsp.done, div_rsp.frac <= bti_pkg::FRAC_ONE,
                  "fraction above one")
  // empty axis always reports zero
  `BTI_ASSERT_NOW(a_empty_zero, out_valid_r && out_data_r.axis_empty,
                  out_data_r.coefficient == '0 && out_data_r.is_lookup_result,
                  "empty-axis result not zero")
endmodule
`default_nettype wire
